### design/aapt_pkg.sv
// Package for the aging address/prefix table.
// Holds the table sizes, the action and event codes and the command type.
// Used by the front, back and top modules; depends on nothing.
`default_nettype none
package aapt_pkg;

    // Table geometry.
    localparam int DEPTH   = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stored entry widths.
    localparam int ADDR_W = 64;
    localparam int PFX_W  = 8;
    localparam int KEY_W  = 2 * ADDR_W + PFX_W;
    localparam int EXP_W  = 32;

    // Expiry limits.
    localparam logic signed [EXP_W-1:0] EXP_MAX     = 32'sh7fff_ffff;
    localparam logic signed [EXP_W-1:0] EXP_MAX_M1  = 32'sh7fff_fffe;
    localparam logic [31:0]             MAPPED_TAG  = 32'h0000_ffff;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_SWEEP  = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_DEMOTE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        EV_INSTALLED = 3'd0,
        EV_REFRESHED = 3'd1,
        EV_FULL      = 3'd2,
        EV_REMOVED   = 3'd3,
        EV_DONE      = 3'd4
    } t_event;

    // One classified command as it waits in the queue.
    typedef struct packed {
        t_action                  action;
        logic [ADDR_W-1:0]        addr_hi;
        logic [ADDR_W-1:0]        addr_lo;
        logic [PFX_W-1:0]         pfx;
        logic signed [EXP_W-1:0]  target;
        logic [30:0]              now;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WALK,
        ST_ADD_FIN,
        ST_RM_WALK,
        ST_RM_FIN,
        ST_DEM_WALK,
        ST_DEM_FIN
    } t_state;

endpackage
`default_nettype wire

### design/aapt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry key and expiry stores; depends on nothing.
`default_nettype none
module aapt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                                          i_clk,
    input  wire                                          i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]                              i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/aapt_front.sv
// Front part: accepts commands, maps IPv4 addresses, works out the target
// expiry and holds the classified commands in a short queue. Uses aapt_pkg.
`default_nettype none
module aapt_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire [1:0]             i_action,
    input  wire                   i_is_ipv4,
    input  wire [63:0]            i_address_high,
    input  wire [63:0]            i_address_low,
    input  wire [7:0]             i_prefix_length,
    input  wire                   i_permanent,
    input  wire signed [31:0]     i_relative_lifetime,
    input  wire [30:0]            i_now_seconds,
    output logic                  o_q_valid,
    output aapt_pkg::t_cmd        o_q_cmd,
    input  wire                   i_q_pop
);
    import aapt_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    t_cmd                cls;
    logic signed [32:0]  sum;
    logic                push, pop;

    // Classify: map IPv4 and saturate the expiry target.
    always_comb begin
        sum        = $signed({2'b00, i_now_seconds}) + $signed({i_relative_lifetime[31],
                                                                 i_relative_lifetime});
        cls.action = t_action'(i_action);
        cls.pfx    = i_prefix_length;
        cls.now    = i_now_seconds;
        if (i_is_ipv4) begin
            cls.addr_hi = '0;
            cls.addr_lo = {MAPPED_TAG, i_address_low[31:0]};
        end else begin
            cls.addr_hi = i_address_high;
            cls.addr_lo = i_address_low;
        end
        if (i_permanent) begin
            cls.target = EXP_MAX;
        end else if (sum > $signed({1'b0, EXP_MAX_M1})) begin
            cls.target = EXP_MAX_M1;
        end else begin
            cls.target = sum[31:0];
        end
    end

    assign busy      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push      = start && !busy;
    assign pop       = i_q_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(pop);
        end
    end
endmodule
`default_nettype wire

### design/aapt_back.sv
// Back part: walks the table to carry out add, sweep, flush and demote,
// keeps the valid bits and the age order, and registers the results.
// Uses aapt_pkg and two aapt_ram instances.
`default_nettype none
module aapt_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  aapt_pkg::t_cmd               i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_strobe,
    output logic [2:0]                   o_event_res,
    output logic                         o_out_is_ipv4,
    output logic [63:0]                  o_out_address_high,
    output logic [63:0]                  o_out_address_low,
    output logic [7:0]                   o_out_prefix_length,
    output logic [aapt_pkg::CNT_W-1:0]   o_affected_count,
    output logic                         o_last
);
    import aapt_pkg::*;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [DEPTH-1:0]        r_valid, n_valid;
    logic [IDX_W-1:0]        r_order [DEPTH];
    logic [IDX_W-1:0]        n_order [DEPTH];
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_wptr, n_wptr;
    logic [CNT_W-1:0]        r_tally, n_tally;
    logic                    r_pv, n_pv;
    logic [IDX_W-1:0]        r_pslot, n_pslot;
    logic                    r_hit, n_hit;
    logic [IDX_W-1:0]        r_hslot, n_hslot;
    logic signed [EXP_W-1:0] r_hexp, n_hexp;

    // Output register.
    logic                    n_ostb, n_olast;
    t_event                  n_oev;
    logic [ADDR_W-1:0]       n_ohi, n_olo;
    logic [PFX_W-1:0]        n_opfx;
    logic [CNT_W-1:0]        n_ocnt;

    // RAM ports.
    logic [IDX_W-1:0]        rd_addr;
    logic                    key_we, exp_we;
    logic [IDX_W-1:0]        key_waddr, exp_waddr;
    logic [KEY_W-1:0]        key_wdata, key_rdata;
    logic [EXP_W-1:0]        exp_wdata, exp_rdata;
    logic signed [EXP_W-1:0] rd_exp;

    // Lowest free slot.
    logic                    free_any;
    logic [IDX_W-1:0]        free_slot;

    aapt_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    aapt_ram #(.WIDTH(EXP_W), .DEPTH(DEPTH)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (exp_we),
        .i_waddr (exp_waddr),
        .i_wdata (exp_wdata),
        .i_raddr (rd_addr),
        .o_rdata (exp_rdata)
    );

    assign rd_exp = $signed(exp_rdata);

    // Priority search for the lowest invalid slot.
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_any  = 1'b1;
                free_slot = IDX_W'(k);
            end
        end
    end

    // Sequencer: next state, walk counters, RAM writes and results.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_valid   = r_valid;
        n_order   = r_order;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wptr    = r_wptr;
        n_tally   = r_tally;
        n_pv      = 1'b0;
        n_pslot   = r_pslot;
        n_hit     = r_hit;
        n_hslot   = r_hslot;
        n_hexp    = r_hexp;
        o_q_pop   = 1'b0;
        rd_addr   = r_idx[IDX_W-1:0];
        key_we    = 1'b0;
        key_waddr = free_slot;
        key_wdata = {r_cmd.addr_hi, r_cmd.addr_lo, r_cmd.pfx};
        exp_we    = 1'b0;
        exp_waddr = r_pslot;
        exp_wdata = '0;
        n_ostb    = 1'b0;
        n_oev     = EV_DONE;
        n_ohi     = '0;
        n_olo     = '0;
        n_opfx    = '0;
        n_ocnt    = '0;
        n_olast   = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    n_wptr  = '0;
                    n_tally = '0;
                    n_hit   = 1'b0;
                    unique case (i_q_cmd.action)
                        ACT_ADD:              n_state = ST_ADD_WALK;
                        ACT_SWEEP, ACT_FLUSH: n_state = ST_RM_WALK;
                        ACT_DEMOTE:           n_state = ST_DEM_WALK;
                        default:              n_state = ST_IDLE;
                    endcase
                end
            end

            ST_ADD_WALK: begin
                // Issue one slot a cycle, compare the previous read.
                if (r_idx != CNT_W'(DEPTH)) begin
                    n_pv    = 1'b1;
                    n_pslot = r_idx[IDX_W-1:0];
                    n_idx   = r_idx + 1'b1;
                end else if (!r_pv) begin
                    n_state = ST_ADD_FIN;
                end
                if (r_pv && r_valid[r_pslot] && !r_hit &&
                    key_rdata == {r_cmd.addr_hi, r_cmd.addr_lo, r_cmd.pfx}) begin
                    n_hit   = 1'b1;
                    n_hslot = r_pslot;
                    n_hexp  = rd_exp;
                end
            end

            ST_ADD_FIN: begin
                n_state = ST_IDLE;
                n_ostb  = 1'b1;
                n_ohi   = r_cmd.addr_hi;
                n_olo   = r_cmd.addr_lo;
                n_opfx  = r_cmd.pfx;
                if (r_hit) begin
                    n_oev     = EV_REFRESHED;
                    exp_waddr = r_hslot;
                    exp_wdata = r_cmd.target;
                    exp_we    = (r_hexp < r_cmd.target);
                end else if (free_any) begin
                    // New entry becomes the newest in the age order.
                    n_oev     = EV_INSTALLED;
                    key_we    = 1'b1;
                    exp_we    = 1'b1;
                    exp_waddr = free_slot;
                    exp_wdata = (r_cmd.target < 0) ? '0 : r_cmd.target;
                    n_valid[free_slot] = 1'b1;
                    for (int k = 1; k < DEPTH; k++) begin
                        n_order[k] = r_order[k-1];
                    end
                    n_order[0] = free_slot;
                    n_count    = r_count + 1'b1;
                end else begin
                    n_oev = EV_FULL;
                end
            end

            ST_RM_WALK: begin
                // Walk the age order newest first, compacting kept entries.
                rd_addr = r_order[r_idx[IDX_W-1:0]];
                if (r_idx != r_count) begin
                    n_pv    = 1'b1;
                    n_pslot = r_order[r_idx[IDX_W-1:0]];
                    n_idx   = r_idx + 1'b1;
                end else if (!r_pv) begin
                    n_state = ST_RM_FIN;
                end
                if (r_pv) begin
                    if (r_cmd.action == ACT_FLUSH ||
                        rd_exp <= $signed({1'b0, r_cmd.now})) begin
                        n_ostb  = 1'b1;
                        n_oev   = EV_REMOVED;
                        n_olast = 1'b0;
                        {n_ohi, n_olo, n_opfx} = key_rdata;
                        n_valid[r_pslot] = 1'b0;
                        n_tally = r_tally + 1'b1;
                    end else begin
                        n_order[r_wptr[IDX_W-1:0]] = r_pslot;
                        n_wptr = r_wptr + 1'b1;
                    end
                end
            end

            ST_RM_FIN: begin
                n_state = ST_IDLE;
                n_count = r_wptr;
                n_ostb  = 1'b1;
                n_ocnt  = r_tally;
            end

            ST_DEM_WALK: begin
                // Read each slot's expiry and write back zero where permanent.
                if (r_idx != CNT_W'(DEPTH)) begin
                    n_pv    = 1'b1;
                    n_pslot = r_idx[IDX_W-1:0];
                    n_idx   = r_idx + 1'b1;
                end else if (!r_pv) begin
                    n_state = ST_DEM_FIN;
                end
                if (r_pv && r_valid[r_pslot] && rd_exp == EXP_MAX) begin
                    exp_we  = 1'b1;
                    n_tally = r_tally + 1'b1;
                end
            end

            ST_DEM_FIN: begin
                n_state = ST_IDLE;
                n_ostb  = 1'b1;
                n_ocnt  = r_tally;
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pv     <= n_pv;
            o_strobe <= n_ostb;
        end
    end

    // Payload and walk bookkeeping.
    always_ff @(posedge i_clk) begin
        r_cmd               <= n_cmd;
        r_order             <= n_order;
        r_wptr              <= n_wptr;
        r_tally             <= n_tally;
        r_pslot             <= n_pslot;
        r_hit               <= n_hit;
        r_hslot             <= n_hslot;
        r_hexp              <= n_hexp;
        o_event_res         <= n_oev;
        o_out_address_high  <= n_ohi;
        o_out_address_low   <= n_olo;
        o_out_prefix_length <= n_opfx;
        o_affected_count    <= n_ocnt;
        o_last              <= n_olast;
        o_out_is_ipv4       <= (n_ohi == '0) && (n_olo[63:32] == MAPPED_TAG);
    end

    // The fill count agrees with the valid bits whenever the sequencer is idle.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> $countones(r_valid) == r_count)
        else $error("entry count out of step with valid bits");

    // Only removals are followed by further results of the same command.
    a_not_last_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_event_res == EV_REMOVED)
        else $error("non-final result that is not a removal");

    // A command is taken from the queue only when the sequencer is idle, and it always starts a walk.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state != ST_IDLE)
        else $error("command popped without starting a walk");

    // The compaction pointer never runs ahead of the read pointer.
    a_wptr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RM_WALK |-> r_wptr <= r_idx)
        else $error("age order compaction overtook the walk");
endmodule
`default_nettype wire

### design/aging_address_prefix_table.sv
// Top level of the aging address/prefix table.
// Joins the front part (aapt_front) and the back part (aapt_back); uses aapt_pkg.
//
// Usage: drive a command on the i_ ports with start high; it is taken at a
// rising edge where start is high and busy is low. Results appear one beat
// per cycle with o_strobe high for exactly one cycle; the receiver must take
// every beat, it cannot stall the block. o_last marks the final beat of a
// command.
// Add: one beat, after a walk over all slots that compares keys through the key
// RAM read port. Sweep and flush: one removed beat per removed entry, newest
// first, then a done beat after a walk over the n stored entries. Demote:
// one done beat after a walk over all slots.
// A two-deep command queue lets start be accepted while the back part walks;
// busy rises when the queue is full, so sustained rate is set by the walks.
// Reset (i_rst_n low, synchronous) empties the table and the queue; stored
// keys and expiry times are not cleared and are read only for valid slots.
`default_nettype none
module aging_address_prefix_table (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [1:0]                    i_action,
    input  wire                          i_is_ipv4,
    input  wire [63:0]                   i_address_high,
    input  wire [63:0]                   i_address_low,
    input  wire [7:0]                    i_prefix_length,
    input  wire                          i_permanent,
    input  wire signed [31:0]            i_relative_lifetime,
    input  wire [30:0]                   i_now_seconds,
    output logic                         o_strobe,
    output logic [2:0]                   o_event_res,
    output logic                         o_out_is_ipv4,
    output logic [63:0]                  o_out_address_high,
    output logic [63:0]                  o_out_address_low,
    output logic [7:0]                   o_out_prefix_length,
    output logic [aapt_pkg::CNT_W-1:0]   o_affected_count,
    output logic                         o_last
);
    import aapt_pkg::*;

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    // Front: classify and queue commands.
    aapt_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_action            (i_action),
        .i_is_ipv4           (i_is_ipv4),
        .i_address_high      (i_address_high),
        .i_address_low       (i_address_low),
        .i_prefix_length     (i_prefix_length),
        .i_permanent         (i_permanent),
        .i_relative_lifetime (i_relative_lifetime),
        .i_now_seconds       (i_now_seconds),
        .o_q_valid           (q_valid),
        .o_q_cmd             (q_cmd),
        .i_q_pop             (q_pop)
    );

    // Back: table walks and result beats.
    aapt_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_cmd             (q_cmd),
        .o_q_pop             (q_pop),
        .o_strobe            (o_strobe),
        .o_event_res         (o_event_res),
        .o_out_is_ipv4       (o_out_is_ipv4),
        .o_out_address_high  (o_out_address_high),
        .o_out_address_low   (o_out_address_low),
        .o_out_prefix_length (o_out_prefix_length),
        .o_affected_count    (o_affected_count),
        .o_last              (o_last)
    );
endmodule
`default_nettype wire
